// File: design/sps_pkg.sv
// shared types, constants and register indexes of the stream piece splitter
package sps_pkg;

    localparam int COUNT_WIDTH        = 32;
    localparam int PIECE_NUMBER_WIDTH = 24;
    localparam int LENGTH_WIDTH       = 32;
    localparam int MAX_SUFFIX_DIGITS  = 8;
    localparam int DIGIT_WIDTH        = 5;
    localparam int DIGIT_COUNT_WIDTH  = 4;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int CFG_DATA_WIDTH     = 32;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [DIGIT_WIDTH-1:0] ALPHA_TOP   = DIGIT_WIDTH'(26 - 1);
    localparam logic [DIGIT_WIDTH-1:0] DECIMAL_TOP = DIGIT_WIDTH'(10 - 1);

    localparam logic [1:0] MODE_BYTES      = 2'd0;
    localparam logic [1:0] MODE_LINES      = 2'd1;
    localparam logic [1:0] MODE_LINE_BYTES = 2'd2;
    localparam logic [1:0] MODE_BYTES_ALT  = 2'd3;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPLIT_MODE     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIECE_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUFFIX_DIGITS  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NUMERIC_SUFFIX = 2'd3;

    localparam logic [1:0]                   RESET_SPLIT_MODE     = MODE_LINES;
    localparam logic [COUNT_WIDTH-1:0]       RESET_LIMIT_M1       = COUNT_WIDTH'(1000 - 1);
    localparam logic [DIGIT_COUNT_WIDTH-1:0] RESET_SUFFIX_DIGITS  = DIGIT_COUNT_WIDTH'(2);
    localparam logic                         RESET_NUMERIC_SUFFIX = 1'b0;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [PIECE_NUMBER_WIDTH-1:0] piece_number;
        logic [LENGTH_WIDTH-1:0]       piece_length;
        logic                          suffix_exhausted;
    } out_word_t;

    typedef struct packed {
        logic                         advance;
        logic [DIGIT_COUNT_WIDTH-1:0] digit_count;
        logic                         numeric;
    } odo_ctrl_t;

endpackage

// File: design/sps_odometer.sv
// suffix odometer: digit registers, ripple advance and the wrapped flag
module sps_odometer
(
    input  logic                clk,
    input  logic                rst_n,
    input  sps_pkg::odo_ctrl_t  ctrl,
    output logic                spent
);

    logic [sps_pkg::DIGIT_WIDTH-1:0] digit_reg  [sps_pkg::MAX_SUFFIX_DIGITS];
    logic [sps_pkg::DIGIT_WIDTH-1:0] digit_next [sps_pkg::MAX_SUFFIX_DIGITS];
    logic                            spent_reg;
    logic                            spent_next;
    logic [sps_pkg::DIGIT_COUNT_WIDTH-1:0] used;
    logic [sps_pkg::DIGIT_WIDTH-1:0]       top;
    logic                                  carry;

    always_comb
    begin
        used = (ctrl.digit_count > sps_pkg::DIGIT_COUNT_WIDTH'(sps_pkg::MAX_SUFFIX_DIGITS))
             ? sps_pkg::DIGIT_COUNT_WIDTH'(sps_pkg::MAX_SUFFIX_DIGITS) : ctrl.digit_count;
        top   = ctrl.numeric ? sps_pkg::DECIMAL_TOP : sps_pkg::ALPHA_TOP;
        carry = 1'b1;
        for (int k = sps_pkg::MAX_SUFFIX_DIGITS - 1; k >= 0; k--)
        begin
            digit_next[k] = digit_reg[k];
            if (sps_pkg::DIGIT_COUNT_WIDTH'(k) < used && carry)
            begin
                if (digit_reg[k] >= top)
                begin
                    digit_next[k] = '0;
                end
                else
                begin
                    digit_next[k] = digit_reg[k] + 1'b1;
                    carry         = 1'b0;
                end
            end
        end
        spent_next = spent_reg | carry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spent_reg <= 1'b0;
            for (int k = 0; k < sps_pkg::MAX_SUFFIX_DIGITS; k++)
            begin
                digit_reg[k] <= '0;
            end
        end
        else if (ctrl.advance)
        begin
            spent_reg <= spent_next;
            for (int k = 0; k < sps_pkg::MAX_SUFFIX_DIGITS; k++)
            begin
                digit_reg[k] <= digit_next[k];
            end
        end
    end

    assign spent = spent_reg;

endmodule

// File: design/stream_piece_splitter.sv
// top level of the stream piece splitter: config, input stage, piece counters, result stage
//
//   channel  direction  handshake                  word
//   data     in         data_valid / data_ready    sps_pkg::in_word_t
//   piece    out        piece_valid / piece_ready  sps_pkg::out_word_t
//   cfg      in         cfg_we (no wait)           cfg_index, cfg_data
//
// one word per cycle sustained while the result side does not stall; a word is processed
// while it sits in the input register, and its result is registered into the output register
// as the word leaves the input register; the counters and the suffix odometer update with it
// reset clears counters, odometer and config to defaults; no clearing pass
// a stalled result holds the output register; the input register then takes a word only
// while empty, and data_ready stays low while it holds one, until the result is taken
module stream_piece_splitter
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   data_valid,
    output logic                                   data_ready,
    input  sps_pkg::in_word_t                      data_word,
    output logic                                   piece_valid,
    input  logic                                   piece_ready,
    output sps_pkg::out_word_t                     piece_word,
    input  logic                                   cfg_we,
    input  logic [sps_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [sps_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    localparam int CW = sps_pkg::COUNT_WIDTH;

    logic [1:0]                            split_mode_reg;
    logic [CW-1:0]                         limit_m1_reg;
    logic [sps_pkg::DIGIT_COUNT_WIDTH-1:0] suffix_digits_reg;
    logic                                  numeric_suffix_reg;

    logic              in_valid_reg;
    sps_pkg::in_word_t in_word_reg;
    logic               out_valid_reg;
    sps_pkg::out_word_t out_word_reg;
    sps_pkg::out_word_t out_word_next;

    logic [CW-1:0] bytes_reg, bytes_next;
    logic [CW-1:0] lines_reg, lines_next;
    logic [CW-1:0] aln_reg, aln_next;
    logic [sps_pkg::PIECE_NUMBER_WIDTH-1:0] counter_reg, counter_next;
    logic halted_reg, halted_next;
    logic claimed_reg, claimed_next;

    logic fire;
    logic emit;
    logic spent;
    logic can_claim;
    logic is_nl;
    logic [1:0] mode;
    logic [CW-1:0] bytes_inc, lines_inc, aln_inc, piece_len;
    sps_pkg::odo_ctrl_t odo_ctrl;

    assign fire       = in_valid_reg && (!out_valid_reg || piece_ready);
    assign data_ready = !in_valid_reg || fire;
    assign is_nl      = in_word_reg.data_byte == sps_pkg::NEWLINE;
    assign mode       = (split_mode_reg == sps_pkg::MODE_BYTES_ALT) ? sps_pkg::MODE_BYTES
                                                                    : split_mode_reg;
    assign can_claim  = claimed_reg || !spent;

    assign bytes_inc = (bytes_reg == sps_pkg::COUNT_MAX) ? bytes_reg : bytes_reg + 1'b1;
    assign lines_inc = (lines_reg == sps_pkg::COUNT_MAX) ? lines_reg : lines_reg + 1'b1;
    assign aln_inc   = (aln_reg == sps_pkg::COUNT_MAX) ? aln_reg : aln_reg + 1'b1;

    always_comb
    begin
        bytes_next    = bytes_reg;
        lines_next    = lines_reg;
        aln_next      = aln_reg;
        counter_next  = counter_reg;
        halted_next   = halted_reg;
        claimed_next  = claimed_reg;
        emit          = 1'b0;
        piece_len     = bytes_inc;
        out_word_next = '{piece_number: counter_reg, piece_length: '0, suffix_exhausted: 1'b0};
        odo_ctrl = '{advance: 1'b0, digit_count: suffix_digits_reg, numeric: numeric_suffix_reg};

        if (!halted_reg)
        begin
            if (in_word_reg.action == sps_pkg::ACTION_END)
            begin
                if (bytes_reg == '0)
                begin
                    claimed_next = 1'b0;
                end
                else if (!can_claim)
                begin
                    emit                           = 1'b1;
                    out_word_next.suffix_exhausted = 1'b1;
                    halted_next                    = 1'b1;
                end
                else
                begin
                    odo_ctrl.advance           = !claimed_reg;
                    emit                       = 1'b1;
                    out_word_next.piece_length = bytes_reg;
                    counter_next               = counter_reg + 1'b1;
                    bytes_next                 = '0;
                    lines_next                 = '0;
                    aln_next                   = '0;
                    claimed_next               = 1'b0;
                end
            end
            else if (mode != sps_pkg::MODE_LINE_BYTES && !can_claim)
            begin
                emit                           = 1'b1;
                out_word_next.suffix_exhausted = 1'b1;
                halted_next                    = 1'b1;
            end
            else
            begin
                bytes_next = bytes_inc;
                if (is_nl)
                begin
                    lines_next = lines_inc;
                    aln_next   = '0;
                end
                else if (lines_reg != '0)
                begin
                    aln_next = aln_inc;
                end

                if (mode != sps_pkg::MODE_LINE_BYTES)
                begin
                    odo_ctrl.advance = !claimed_reg;
                    claimed_next     = 1'b1;
                end

                unique case (mode)
                    sps_pkg::MODE_LINES:
                    begin
                        emit = is_nl && (lines_reg >= limit_m1_reg);
                    end
                    sps_pkg::MODE_LINE_BYTES:
                    begin
                        emit = bytes_reg >= limit_m1_reg;
                        if (lines_next != '0 && aln_next < bytes_inc)
                        begin
                            piece_len = bytes_inc - aln_next;
                        end
                    end
                    default:
                    begin
                        emit = bytes_reg >= limit_m1_reg;
                    end
                endcase

                if (emit)
                begin
                    if (mode == sps_pkg::MODE_LINE_BYTES && !can_claim)
                    begin
                        out_word_next.suffix_exhausted = 1'b1;
                        halted_next                    = 1'b1;
                    end
                    else
                    begin
                        odo_ctrl.advance           = !claimed_reg;
                        out_word_next.piece_length = piece_len;
                        counter_next               = counter_reg + 1'b1;
                        bytes_next                 = bytes_inc - piece_len;
                        lines_next                 = '0;
                        aln_next                   = '0;
                        claimed_next               = 1'b0;
                    end
                end
            end
        end

        if (!fire)
        begin
            odo_ctrl.advance = 1'b0;
        end
    end

    sps_odometer u_odometer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (odo_ctrl),
        .spent (spent)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode_reg     <= sps_pkg::RESET_SPLIT_MODE;
            limit_m1_reg       <= sps_pkg::RESET_LIMIT_M1;
            suffix_digits_reg  <= sps_pkg::RESET_SUFFIX_DIGITS;
            numeric_suffix_reg <= sps_pkg::RESET_NUMERIC_SUFFIX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sps_pkg::REG_SPLIT_MODE:
                begin
                    split_mode_reg <= cfg_data[1:0];
                end
                sps_pkg::REG_PIECE_LIMIT:
                begin
                    limit_m1_reg <= (cfg_data == '0) ? '0 : CW'(cfg_data - 1'b1);
                end
                sps_pkg::REG_SUFFIX_DIGITS:
                begin
                    suffix_digits_reg <= cfg_data[sps_pkg::DIGIT_COUNT_WIDTH-1:0];
                end
                sps_pkg::REG_NUMERIC_SUFFIX:
                begin
                    numeric_suffix_reg <= cfg_data[0];
                end
            endcase
        end
    end

    // input stage, piece state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bytes_reg     <= '0;
            lines_reg     <= '0;
            aln_reg       <= '0;
            counter_reg   <= '0;
            halted_reg    <= 1'b0;
            claimed_reg   <= 1'b0;
        end
        else
        begin
            if (data_ready)
            begin
                in_valid_reg <= data_valid;
            end
            if (fire)
            begin
                out_valid_reg <= emit;
                bytes_reg     <= bytes_next;
                lines_reg     <= lines_next;
                aln_reg       <= aln_next;
                counter_reg   <= counter_next;
                halted_reg    <= halted_next;
                claimed_reg   <= claimed_next;
            end
            else if (piece_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            in_word_reg <= data_word;
        end
        if (fire && emit)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign piece_valid = out_valid_reg;
    assign piece_word  = out_word_reg;

endmodule

// File: design/sps_checker.sv
// port-level checker for the stream piece splitter, bound to the top level
module sps_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                data_valid,
    input logic                                data_ready,
    input sps_pkg::in_word_t                   data_word,
    input logic                                piece_valid,
    input logic                                piece_ready,
    input sps_pkg::out_word_t                  piece_word,
    input logic                                cfg_we,
    input logic [sps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input logic [sps_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !piece_ready |=> piece_valid && $stable(piece_word))
        else $error("result word changed while stalled");

    // exhaustion words carry zero length, real pieces never do
    a_len_flag: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid |-> (piece_word.suffix_exhausted == (piece_word.piece_length == '0)))
        else $error("length and exhausted flag disagree");

    // nothing follows a taken exhaustion word
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && piece_ready && piece_word.suffix_exhausted |=> !piece_valid)
        else $error("result after suffix exhaustion");

    // an empty result stage never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !piece_valid |-> data_ready)
        else $error("input stalled with empty result stage");

endmodule

bind stream_piece_splitter sps_checker u_sps_checker (.*);

// File: sim/stream_piece_splitter_tb.sv
// testbench of the stream piece splitter: directed word table, random setting phases, model check
`timescale 1ns / 1ps

module stream_piece_splitter_tb;

    localparam int RANDOM_WORDS   = 1200;
    localparam int PHASES         = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DRAIN_LIMIT    = 500;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {ROW_WORD, ROW_SETTINGS} row_kind_t;

    typedef struct packed {
        logic               typed;
        logic               has_piece;
        sps_pkg::out_word_t want;
    } word_mark_t;

    typedef struct packed {
        row_kind_t                             kind;
        sps_pkg::in_word_t                     word;
        logic [1:0]                            mode;
        logic [sps_pkg::CFG_DATA_WIDTH-1:0]    limit;
        logic [sps_pkg::DIGIT_COUNT_WIDTH-1:0] digits;
        logic                                  numeric;
        word_mark_t                            mark;
    } plan_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                data_valid;
    logic                                data_ready;
    sps_pkg::in_word_t                   data_word;
    logic                                piece_valid;
    logic                                piece_ready;
    sps_pkg::out_word_t                  piece_word;
    logic                                cfg_we;
    logic [sps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [sps_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    // splitter model state
    logic [1:0]                             set_mode;
    logic [sps_pkg::CFG_DATA_WIDTH-1:0]     set_limit;
    logic [sps_pkg::DIGIT_COUNT_WIDTH-1:0]  set_digits;
    logic                                   set_numeric;
    logic [sps_pkg::COUNT_WIDTH-1:0]        bytes_held;
    logic [sps_pkg::COUNT_WIDTH-1:0]        lines_held;
    logic [sps_pkg::COUNT_WIDTH-1:0]        tail_held;
    logic [sps_pkg::PIECE_NUMBER_WIDTH-1:0] next_number;
    logic [sps_pkg::DIGIT_WIDTH-1:0]        suffix_at [sps_pkg::MAX_SUFFIX_DIGITS];
    bit                                     frozen;
    bit                                     odo_wrapped;
    bit                                     has_suffix;

    sps_pkg::out_word_t pieces_due [$];
    word_mark_t         word_marks [$];
    plan_row_t          plan [$];

    int  failures;
    int  words_taken;
    int  pieces_checked;
    int  settings_applied;
    int  exhaustion_seen;
    int  quiet;
    bit  calm;
    bit  squeeze_ask;

    stream_piece_splitter dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_ready  (data_ready),
        .data_word   (data_word),
        .piece_valid (piece_valid),
        .piece_ready (piece_ready),
        .piece_word  (piece_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [sps_pkg::COUNT_WIDTH-1:0] sat_up(
        logic [sps_pkg::COUNT_WIDTH-1:0] v);
        return (v == sps_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bit take_suffix();
        int n;
        logic [sps_pkg::DIGIT_WIDTH-1:0] top;
        if (has_suffix)
            return 1'b1;
        if (odo_wrapped)
            return 1'b0;
        has_suffix = 1'b1;
        n = (set_digits > sps_pkg::MAX_SUFFIX_DIGITS) ? sps_pkg::MAX_SUFFIX_DIGITS : set_digits;
        top = set_numeric ? sps_pkg::DECIMAL_TOP : sps_pkg::ALPHA_TOP;
        while (n != 0)
        begin
            n--;
            if (suffix_at[n] < top)
            begin
                suffix_at[n] = suffix_at[n] + 1'b1;
                return 1'b1;
            end
            suffix_at[n] = '0;
        end
        odo_wrapped = 1'b1;
        return 1'b1;
    endfunction

    function automatic sps_pkg::out_word_t close_piece(logic [sps_pkg::COUNT_WIDTH-1:0] len);
        sps_pkg::out_word_t r;
        r.piece_number     = next_number;
        r.piece_length     = sps_pkg::LENGTH_WIDTH'(len);
        r.suffix_exhausted = 1'b0;
        next_number = next_number + 1'b1;
        has_suffix  = 1'b0;
        return r;
    endfunction

    function automatic sps_pkg::out_word_t refuse_piece();
        sps_pkg::out_word_t r;
        r.piece_number     = next_number;
        r.piece_length     = '0;
        r.suffix_exhausted = 1'b1;
        frozen = 1'b1;
        return r;
    endfunction

    function automatic void clear_piece();
        bytes_held = '0;
        lines_held = '0;
        tail_held  = '0;
        has_suffix = 1'b0;
    endfunction

    // advances the model by one word; returns 1 when the word finishes a piece or yields an exhaustion word
    function automatic bit cut_word(sps_pkg::in_word_t w, output sps_pkg::out_word_t r);
        logic [1:0]                         mode;
        logic [sps_pkg::CFG_DATA_WIDTH-1:0] lim;
        logic [sps_pkg::COUNT_WIDTH-1:0]    len;
        bit                                 nl;
        mode = (set_mode == sps_pkg::MODE_BYTES_ALT) ? sps_pkg::MODE_BYTES : set_mode;
        lim  = (set_limit == '0) ? sps_pkg::CFG_DATA_WIDTH'(1) : set_limit;
        nl   = (w.data_byte == sps_pkg::NEWLINE);
        r    = '0;
        if (frozen)
            return 1'b0;
        if (w.action == sps_pkg::ACTION_END)
        begin
            len = bytes_held;
            if (len == '0)
            begin
                clear_piece();
                return 1'b0;
            end
            if (!take_suffix())
            begin
                r = refuse_piece();
                return 1'b1;
            end
            r = close_piece(len);
            clear_piece();
            return 1'b1;
        end
        if (mode != sps_pkg::MODE_LINE_BYTES && !take_suffix())
        begin
            r = refuse_piece();
            return 1'b1;
        end
        bytes_held = sat_up(bytes_held);
        if (nl)
        begin
            lines_held = sat_up(lines_held);
            tail_held  = '0;
        end
        else if (lines_held != '0)
            tail_held = sat_up(tail_held);
        case (mode)
            sps_pkg::MODE_BYTES:
                if (bytes_held >= lim)
                begin
                    r = close_piece(bytes_held);
                    clear_piece();
                    return 1'b1;
                end
            sps_pkg::MODE_LINES:
                if (nl && lines_held >= lim)
                begin
                    r = close_piece(bytes_held);
                    clear_piece();
                    return 1'b1;
                end
            default:
                if (bytes_held >= lim)
                begin
                    len = bytes_held;
                    // cut after the last newline of a full buffer
                    if (lines_held != '0 && tail_held < bytes_held)
                        len = bytes_held - tail_held;
                    if (!take_suffix())
                    begin
                        r = refuse_piece();
                        return 1'b1;
                    end
                    r = close_piece(len);
                    bytes_held = bytes_held - len;
                    lines_held = '0;
                    tail_held  = '0;
                    return 1'b1;
                end
        endcase
        return 1'b0;
    endfunction

    function automatic void plan_word(logic action, logic [7:0] data);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.word.action    = action;
        r.word.data_byte = data;
        plan.push_back(r);
    endfunction

    function automatic void plan_typed(logic action, logic [7:0] data, logic has_piece,
                                       logic [sps_pkg::PIECE_NUMBER_WIDTH-1:0] number,
                                       logic [sps_pkg::LENGTH_WIDTH-1:0] length);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.word.action    = action;
        r.word.data_byte = data;
        r.mark.typed     = 1'b1;
        r.mark.has_piece = has_piece;
        r.mark.want.piece_number = number;
        r.mark.want.piece_length = length;
        plan.push_back(r);
    endfunction

    function automatic void plan_settings(logic [1:0] mode,
                                          logic [sps_pkg::CFG_DATA_WIDTH-1:0] limit,
                                          logic [sps_pkg::DIGIT_COUNT_WIDTH-1:0] digits,
                                          logic numeric);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_SETTINGS;
        r.mode    = mode;
        r.limit   = limit;
        r.digits  = digits;
        r.numeric = numeric;
        plan.push_back(r);
    endfunction

    function automatic sps_pkg::in_word_t pick_word();
        sps_pkg::in_word_t w;
        w.action    = ($urandom_range(0, 31) == 0) ? sps_pkg::ACTION_END : sps_pkg::ACTION_BYTE;
        w.data_byte = ($urandom_range(0, 3) == 0) ? sps_pkg::NEWLINE
                                                  : 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic offer_word(sps_pkg::in_word_t w, word_mark_t mark);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        word_marks.push_back(mark);
        data_valid <= 1'b1;
        data_word  <= w;
        @(posedge clk);
        while (!data_ready) @(posedge clk);
    endtask

    task automatic put_reg(logic [sps_pkg::CFG_INDEX_WIDTH-1:0] index,
                           logic [sps_pkg::CFG_DATA_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(logic [1:0] mode, logic [sps_pkg::CFG_DATA_WIDTH-1:0] limit,
                                  logic [sps_pkg::DIGIT_COUNT_WIDTH-1:0] digits,
                                  logic numeric);
        data_valid <= 1'b0;
        @(posedge clk);
        while (pieces_due.size() != 0 || word_marks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_reg(sps_pkg::REG_SPLIT_MODE, sps_pkg::CFG_DATA_WIDTH'(mode));
        put_reg(sps_pkg::REG_PIECE_LIMIT, limit);
        put_reg(sps_pkg::REG_SUFFIX_DIGITS, sps_pkg::CFG_DATA_WIDTH'(digits));
        put_reg(sps_pkg::REG_NUMERIC_SUFFIX, sps_pkg::CFG_DATA_WIDTH'(numeric));
        cfg_we <= 1'b0;
        set_mode    = mode;
        set_limit   = limit;
        set_digits  = digits;
        set_numeric = numeric;
        settings_applied++;
    endtask

    task automatic choose_random_settings();
        logic [1:0]                            mode;
        logic [sps_pkg::CFG_DATA_WIDTH-1:0]    limit;
        logic [sps_pkg::DIGIT_COUNT_WIDTH-1:0] digits;
        mode = 2'($urandom_range(sps_pkg::MODE_BYTES, sps_pkg::MODE_BYTES_ALT));
        case ($urandom_range(0, 9))
            0: limit = '0;
            1: limit = '1;
            2: limit = $urandom();
            default: limit = $urandom_range(1, 12);
        endcase
        // keep enough suffix room so the odometer does not run out early
        digits = ($urandom_range(0, 3) == 0)
               ? '1
               : sps_pkg::DIGIT_COUNT_WIDTH'($urandom_range(4, sps_pkg::MAX_SUFFIX_DIGITS));
        apply_settings(mode, limit, digits, 1'($urandom_range(0, 1)));
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        piece_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_ask)
            begin
                squeeze_ask = 1'b0;
                piece_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                piece_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            piece_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sps_pkg::out_word_t got;
        sps_pkg::out_word_t want;
        word_mark_t         mark;
        bit                 made;
        if (rst_n)
        begin
            if (data_valid && data_ready)
            begin
                mark = word_marks.pop_front();
                made = cut_word(data_word, got);
                if (mark.typed)
                begin
                    made = mark.has_piece;
                    got  = mark.want;
                end
                if (made)
                    pieces_due.push_back(got);
                words_taken++;
            end
            if (piece_valid && piece_ready)
            begin
                if (pieces_due.size() == 0)
                begin
                    $error("piece with nothing expected: number %0d, length %0d",
                           piece_word.piece_number, piece_word.piece_length);
                    failures++;
                end
                else
                begin
                    want = pieces_due.pop_front();
                    if (piece_word.piece_number !== want.piece_number)
                    begin
                        $error("piece_number: expected %0d, got %0d",
                               want.piece_number, piece_word.piece_number);
                        failures++;
                    end
                    if (piece_word.piece_length !== want.piece_length)
                    begin
                        $error("piece_length: expected %0d, got %0d",
                               want.piece_length, piece_word.piece_length);
                        failures++;
                    end
                    if (piece_word.suffix_exhausted !== want.suffix_exhausted)
                    begin
                        $error("suffix_exhausted: expected %0d, got %0d",
                               want.suffix_exhausted, piece_word.suffix_exhausted);
                        failures++;
                    end
                    if (want.suffix_exhausted)
                        exhaustion_seen++;
                    pieces_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (data_valid && data_ready) || (piece_valid && piece_ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet == WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        data_valid  = 1'b0;
        data_word   = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        calm        = 1'b0;
        squeeze_ask = 1'b0;
        set_mode    = sps_pkg::RESET_SPLIT_MODE;
        set_limit   = sps_pkg::RESET_LIMIT_M1 + 1'b1;
        set_digits  = sps_pkg::RESET_SUFFIX_DIGITS;
        set_numeric = sps_pkg::RESET_NUMERIC_SUFFIX;
        bytes_held  = '0;
        lines_held  = '0;
        tail_held   = '0;
        next_number = '0;
        foreach (suffix_at[i])
            suffix_at[i] = '0;
        frozen      = 1'b0;
        odo_wrapped = 1'b0;
        has_suffix  = 1'b0;

        // defaults after reset: lines mode, limit 1000
        plan_typed(sps_pkg::ACTION_BYTE, 8'h00, 1'b0, '0, '0);
        plan_typed(sps_pkg::ACTION_BYTE, 8'hFF, 1'b0, '0, '0);
        plan_typed(sps_pkg::ACTION_END, sps_pkg::NEWLINE, 1'b1, 24'd0, 32'd2);
        plan_typed(sps_pkg::ACTION_END, 8'h00, 1'b0, '0, '0);
        plan_settings(sps_pkg::MODE_BYTES, 32'd3, 4'd2, 1'b0);
        plan_word(sps_pkg::ACTION_BYTE, 8'h61);
        plan_word(sps_pkg::ACTION_BYTE, sps_pkg::NEWLINE);
        plan_typed(sps_pkg::ACTION_BYTE, 8'h80, 1'b1, 24'd1, 32'd3);
        // zero limit counts as one
        plan_settings(sps_pkg::MODE_BYTES, 32'd0, 4'd2, 1'b0);
        plan_typed(sps_pkg::ACTION_BYTE, 8'h55, 1'b1, 24'd2, 32'd1);
        plan_settings(sps_pkg::MODE_LINES, 32'd2, 4'd2, 1'b1);
        plan_word(sps_pkg::ACTION_BYTE, 8'h78);
        plan_word(sps_pkg::ACTION_BYTE, sps_pkg::NEWLINE);
        plan_word(sps_pkg::ACTION_BYTE, 8'h79);
        plan_word(sps_pkg::ACTION_BYTE, sps_pkg::NEWLINE);
        // line-bytes: cut at newline, then a full buffer with no newline
        plan_settings(sps_pkg::MODE_LINE_BYTES, 32'd4, 4'd8, 1'b0);
        plan_word(sps_pkg::ACTION_BYTE, 8'h61);
        plan_word(sps_pkg::ACTION_BYTE, sps_pkg::NEWLINE);
        plan_word(sps_pkg::ACTION_BYTE, 8'h62);
        plan_word(sps_pkg::ACTION_BYTE, 8'h63);
        plan_word(sps_pkg::ACTION_BYTE, 8'h64);
        plan_word(sps_pkg::ACTION_BYTE, 8'h65);
        plan_word(sps_pkg::ACTION_BYTE, sps_pkg::NEWLINE);
        plan_word(sps_pkg::ACTION_END, 8'hA5);
        plan_settings(sps_pkg::MODE_BYTES_ALT, 32'd2, 4'd8, 1'b1);
        plan_word(sps_pkg::ACTION_BYTE, sps_pkg::NEWLINE);
        plan_word(sps_pkg::ACTION_BYTE, 8'h41);
        // partial piece kept across a limit drop
        plan_settings(sps_pkg::MODE_BYTES, '1, 4'd15, 1'b1);
        plan_word(sps_pkg::ACTION_BYTE, 8'h7A);
        plan_word(sps_pkg::ACTION_BYTE, 8'h71);
        plan_settings(sps_pkg::MODE_LINE_BYTES, 32'd1, 4'd15, 1'b0);
        plan_word(sps_pkg::ACTION_BYTE, sps_pkg::NEWLINE);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETTINGS)
                apply_settings(plan[i].mode, plan[i].limit, plan[i].digits, plan[i].numeric);
            else
                offer_word(plan[i].word, plan[i].mark);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // one piece per word while the receiver holds off, so the block fills
            if (p == 1)
            begin
                apply_settings(sps_pkg::MODE_BYTES, 32'd1, 4'd8, 1'b0);
                squeeze_ask = 1'b1;
            end
            else
                choose_random_settings();
            if (p == PHASES - 1)
                calm = 1'b1;
            repeat (RANDOM_WORDS / PHASES) offer_word(pick_word(), '0);
        end

        // zero digits: one more suffix, then the block must stop for good
        apply_settings(sps_pkg::MODE_BYTES, 32'd1, '0, 1'b0);
        for (int n = 0; n < 40 && !frozen; n++)
            offer_word({sps_pkg::ACTION_BYTE, 8'($urandom_range(0, 255))}, '0);
        repeat (8) offer_word(pick_word(), '0);

        data_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && pieces_due.size() != 0; n++)
            @(posedge clk);
        if (pieces_due.size() != 0)
        begin
            $error("%0d pieces never arrived", pieces_due.size());
            failures++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d stream words over %0d register settings, %0d pieces compared",
                 words_taken, settings_applied, pieces_checked);
        $display("suffix exhaustion %s",
                 (exhaustion_seen != 0) ? "reached and held" : "not reached");
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
